@@ src/matrix_norm_engine_top_macros.svh @@
// ---------------------------------------------------------------------------
// matrix norm engine assertion macros
// shared assertion wrappers, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef MATRIX_NORM_ENGINE_TOP_MACROS_SVH
`define MATRIX_NORM_ENGINE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define MNE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mne check failed");
`define MNE_ASSERT_IMP(name, ante, cons) \
  `MNE_ASSERT(name, (ante) |-> (cons))
`else
`define MNE_ASSERT(name, prop)
`define MNE_ASSERT_IMP(name, ante, cons)
`endif

`endif

@@ src/mne_pkg.sv @@
// ---------------------------------------------------------------------------
// mne_pkg
// shared widths, codes and types of the matrix norm engine
// ---------------------------------------------------------------------------
package mne_pkg;

  localparam int MaxColsDef = 64;

  localparam int ElemW    = 32;
  localparam int MagW     = 32;
  localparam int SumW     = 48;
  localparam int SqW      = 64;
  localparam int RootW    = 32;
  localparam int RowW     = 16;
  localparam int ColCfgW  = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_RUN,
    BK_LAST,
    BK_WALK,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    logic row_end;
    logic last;
  } q_flags_t;

endpackage

@@ src/mne_ram.sv @@
// ---------------------------------------------------------------------------
// mne_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module mne_ram #(
  parameter int Width = 48,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mne_front.sv @@
// ---------------------------------------------------------------------------
// mne_front
// takes words, forms magnitude and position flags, queues them for the back
// ---------------------------------------------------------------------------
module mne_front #(
  parameter int MaxCols = mne_pkg::MaxColsDef,
  localparam int ColW    = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  localparam int ColCntW = $clog2(MaxCols + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clr_i,
  input  logic                            hold_i,
  input  logic [ColCntW-1:0]              cols_i,
  input  logic [mne_pkg::RowW-1:0]        rows_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic signed [mne_pkg::ElemW-1:0] element_i,
  input  logic                            q_pop_i,
  output logic                            q_empty_o,
  output logic [mne_pkg::MagW-1:0]        q_mag_o,
  output logic [ColW-1:0]                 q_col_o,
  output mne_pkg::q_flags_t               q_flags_o
);

  logic [ColW-1:0]             col_q, col_d;
  logic [mne_pkg::RowW-1:0]    row_q, row_d;
  logic [mne_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [mne_pkg::QCntW-1:0]   cnt_q;

  logic [mne_pkg::MagW-1:0]    mag_mem_q   [mne_pkg::QueueDepth];
  logic [ColW-1:0]             col_mem_q   [mne_pkg::QueueDepth];
  mne_pkg::q_flags_t           flags_mem_q [mne_pkg::QueueDepth];

  logic                        accept;
  logic [mne_pkg::ElemW-1:0]   raw;
  logic [mne_pkg::MagW-1:0]    mag;
  logic [ColCntW-1:0]          col_p1;
  logic [mne_pkg::RowW:0]      row_p1;
  mne_pkg::q_flags_t           flags;
  logic                        do_pop;

  // no word is taken while a config write resets the position
  assign full_o    = (cnt_q == mne_pkg::QCntW'(mne_pkg::QueueDepth)) || hold_i || clr_i;
  assign accept    = push_i && !full_o;
  assign q_empty_o = (cnt_q == '0);
  assign do_pop    = q_pop_i && !q_empty_o;

  // magnitude, -2^31 maps to 2^31
  assign raw = element_i;
  assign mag = raw[mne_pkg::ElemW-1] ? (~raw + mne_pkg::MagW'(1)) : raw;

  assign col_p1        = ColCntW'(col_q) + ColCntW'(1);
  assign row_p1        = {1'b0, row_q} + (mne_pkg::RowW + 1)'(1);
  assign flags.row_end = (col_p1 >= cols_i);
  assign flags.last    = flags.row_end && (row_p1 >= {1'b0, rows_i});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (flags.row_end) begin
        col_d = '0;
        row_d = flags.last ? '0 : row_p1[mne_pkg::RowW-1:0];
      end else begin
        col_d = col_p1[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else if (clr_i) begin
      col_q    <= '0;
      row_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + mne_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + mne_pkg::QPtrW'(1);
      end
      if (accept && !do_pop) begin
        cnt_q <= cnt_q + mne_pkg::QCntW'(1);
      end else if (!accept && do_pop) begin
        cnt_q <= cnt_q - mne_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_mem_q[wr_ptr_q]   <= mag;
      col_mem_q[wr_ptr_q]   <= col_q;
      flags_mem_q[wr_ptr_q] <= flags;
    end
  end

  assign q_mag_o   = mag_mem_q[rd_ptr_q];
  assign q_col_o   = col_mem_q[rd_ptr_q];
  assign q_flags_o = flags_mem_q[rd_ptr_q];

endmodule

@@ src/mne_isqrt.sv @@
// ---------------------------------------------------------------------------
// mne_isqrt
// digit by digit integer square root, one result bit per cycle
// ---------------------------------------------------------------------------
module mne_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mne_pkg::SqW-1:0]   value_i,
  output logic                      busy_o,
  output logic [mne_pkg::RootW-1:0] root_o
);

  logic                    busy_q;
  logic [mne_pkg::SqW-1:0] v_q, res_q, bit_q;
  logic [mne_pkg::SqW-1:0] trial;
  logic                    fits;

  assign trial = res_q + bit_q;
  assign fits  = (v_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q) begin
      busy_q <= ((bit_q >> 2) != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= mne_pkg::SqW'(1) << (mne_pkg::SqW - 2);
    end else if (busy_q) begin
      if (fits) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[mne_pkg::RootW-1:0];

endmodule

@@ src/mne_back.sv @@
// ---------------------------------------------------------------------------
// mne_back
// accumulates the queued words, then walks the column sums and takes the root
// ---------------------------------------------------------------------------
`include "matrix_norm_engine_top_macros.svh"

module mne_back #(
  parameter int MaxCols = mne_pkg::MaxColsDef,
  localparam int ColW    = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  localparam int ColCntW = $clog2(MaxCols + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic [ColCntW-1:0]         cols_i,
  output logic                       clearing_o,
  input  logic                       q_empty_i,
  input  logic [mne_pkg::MagW-1:0]   q_mag_i,
  input  logic [ColW-1:0]            q_col_i,
  input  mne_pkg::q_flags_t          q_flags_i,
  output logic                       q_pop_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [mne_pkg::MagW-1:0]   max_abs_norm_o,
  output logic [mne_pkg::SumW-1:0]   infinity_norm_o,
  output logic [mne_pkg::SumW-1:0]   one_norm_o,
  output logic [mne_pkg::RootW-1:0]  frobenius_norm_o
);

  localparam logic [ColCntW-1:0] LastCol = ColCntW'(MaxCols - 1);

  function automatic logic [mne_pkg::SumW-1:0] sat_add48(
    input logic [mne_pkg::SumW-1:0] a,
    input logic [mne_pkg::MagW-1:0] b
  );
    logic [mne_pkg::SumW:0] s;
    s = {1'b0, a} + (mne_pkg::SumW + 1)'(b);
    return s[mne_pkg::SumW] ? '1 : s[mne_pkg::SumW-1:0];
  endfunction

  mne_pkg::back_state_e state_q, state_d;
  logic [ColCntW-1:0]   cnt_q;

  // stage one, loaded on pop
  logic                      s1_valid_q;
  logic [mne_pkg::MagW-1:0]  s1_mag_q;
  logic [ColW-1:0]           s1_col_q;
  logic                      s1_row_end_q;
  logic [mne_pkg::SqW-1:0]   s1_sq_q;

  logic                      fwd_valid_q;
  logic [ColW-1:0]           fwd_col_q;
  logic [mne_pkg::SumW-1:0]  fwd_sum_q;

  logic [mne_pkg::MagW-1:0]  max_abs_q;
  logic [mne_pkg::SumW-1:0]  row_sum_q, best_q;
  logic [mne_pkg::SqW-1:0]   sqsum_q;

  logic [mne_pkg::MagW-1:0]  res_max_q;
  logic [mne_pkg::SumW-1:0]  res_inf_q;

  logic                      walk_rd_q;
  logic [ColW-1:0]           walk_addr_q;
  logic [mne_pkg::SumW-1:0]  one_max_q;

  logic                      out_valid_q;
  logic [mne_pkg::MagW-1:0]  out_max_q;
  logic [mne_pkg::SumW-1:0]  out_inf_q, out_one_q;
  logic [mne_pkg::RootW-1:0] out_frob_q;

  logic                      pop, walk_issue, load_out, sqrt_start, sqrt_busy;
  logic [mne_pkg::RootW-1:0] sqrt_root;

  logic                      ram_we, ram_re;
  logic [ColW-1:0]           ram_waddr, ram_raddr;
  logic [mne_pkg::SumW-1:0]  ram_wdata, ram_rdata;

  logic [mne_pkg::SumW-1:0]  colsum_old, colsum_new, row_sum_new, best_next, row_next;
  logic [mne_pkg::MagW-1:0]  max_next;
  logic [mne_pkg::SqW:0]     sq_wide;
  logic [mne_pkg::SqW-1:0]   sq_next;

  always_comb begin
    state_d    = state_q;
    pop        = 1'b0;
    walk_issue = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      mne_pkg::BK_CLEAR: begin
        if (cnt_q == LastCol) begin
          state_d = mne_pkg::BK_RUN;
        end
      end
      mne_pkg::BK_RUN: begin
        if (!q_empty_i) begin
          pop = 1'b1;
          if (q_flags_i.last) begin
            state_d = mne_pkg::BK_LAST;
          end
        end
      end
      mne_pkg::BK_LAST: begin
        state_d = mne_pkg::BK_WALK;
      end
      mne_pkg::BK_WALK: begin
        walk_issue = (cnt_q < cols_i);
        if (!walk_issue && !walk_rd_q) begin
          state_d = mne_pkg::BK_FINISH;
        end
      end
      mne_pkg::BK_FINISH: begin
        if (!sqrt_busy && (!out_valid_q || pop_i)) begin
          load_out = 1'b1;
          state_d  = mne_pkg::BK_RUN;
        end
      end
      default: state_d = mne_pkg::BK_CLEAR;
    endcase
    if (clr_i) begin
      state_d = mne_pkg::BK_CLEAR;
    end
  end

  assign q_pop_o    = pop;
  assign clearing_o = (state_q == mne_pkg::BK_CLEAR);
  assign sqrt_start = (state_q == mne_pkg::BK_LAST);

  // accumulate, forwarding the previous column write for back to back hits
  assign colsum_old  = (fwd_valid_q && (fwd_col_q == s1_col_q)) ? fwd_sum_q : ram_rdata;
  assign colsum_new  = sat_add48(colsum_old, s1_mag_q);
  assign row_sum_new = sat_add48(row_sum_q, s1_mag_q);
  assign max_next    = (s1_mag_q > max_abs_q) ? s1_mag_q : max_abs_q;
  assign sq_wide     = {1'b0, sqsum_q} + {1'b0, s1_sq_q};
  assign sq_next     = sq_wide[mne_pkg::SqW] ? '1 : sq_wide[mne_pkg::SqW-1:0];
  assign best_next   = (s1_row_end_q && (row_sum_new > best_q)) ? row_sum_new : best_q;
  assign row_next    = s1_row_end_q ? '0 : row_sum_new;

  // column ram port selection
  assign ram_we    = clearing_o || s1_valid_q || walk_rd_q;
  assign ram_waddr = clearing_o ? cnt_q[ColW-1:0] : (walk_rd_q ? walk_addr_q : s1_col_q);
  assign ram_wdata = s1_valid_q ? colsum_new : '0;
  assign ram_re    = pop || walk_issue;
  assign ram_raddr = walk_issue ? cnt_q[ColW-1:0] : q_col_i;

  mne_ram #(
    .Width (mne_pkg::SumW),
    .Depth (MaxCols)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mne_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sq_next),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mne_pkg::BK_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      walk_rd_q   <= 1'b0;
      max_abs_q   <= '0;
      row_sum_q   <= '0;
      best_q      <= '0;
      sqsum_q     <= '0;
      one_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (clr_i) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      walk_rd_q   <= 1'b0;
      max_abs_q   <= '0;
      row_sum_q   <= '0;
      best_q      <= '0;
      sqsum_q     <= '0;
      one_max_q   <= '0;
      // a waiting result word can still be taken
      if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end else begin
      s1_valid_q  <= pop;
      fwd_valid_q <= s1_valid_q;
      walk_rd_q   <= walk_issue;
      if (clearing_o || walk_issue) begin
        cnt_q <= cnt_q + ColCntW'(1);
      end else if (state_q == mne_pkg::BK_LAST) begin
        cnt_q <= '0;
      end
      if (s1_valid_q) begin
        if (state_q == mne_pkg::BK_LAST) begin
          max_abs_q <= '0;
          row_sum_q <= '0;
          best_q    <= '0;
          sqsum_q   <= '0;
        end else begin
          max_abs_q <= max_next;
          row_sum_q <= row_next;
          best_q    <= best_next;
          sqsum_q   <= sq_next;
        end
      end
      if (state_q == mne_pkg::BK_LAST) begin
        one_max_q <= '0;
      end else if (walk_rd_q && (ram_rdata > one_max_q)) begin
        one_max_q <= ram_rdata;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_mag_q     <= q_mag_i;
      s1_col_q     <= q_col_i;
      s1_row_end_q <= q_flags_i.row_end;
      s1_sq_q      <= q_mag_i * q_mag_i;
    end
    fwd_col_q   <= s1_col_q;
    fwd_sum_q   <= colsum_new;
    walk_addr_q <= cnt_q[ColW-1:0];
    if (state_q == mne_pkg::BK_LAST) begin
      res_max_q <= max_next;
      res_inf_q <= best_next;
    end
    if (load_out) begin
      out_max_q  <= res_max_q;
      out_inf_q  <= res_inf_q;
      out_one_q  <= one_max_q;
      out_frob_q <= sqrt_root;
    end
  end

  assign empty_o          = !out_valid_q;
  assign max_abs_norm_o   = out_max_q;
  assign infinity_norm_o  = out_inf_q;
  assign one_norm_o       = out_one_q;
  assign frobenius_norm_o = out_frob_q;

  `MNE_ASSERT_IMP(a_last_holds_word, state_q == mne_pkg::BK_LAST, s1_valid_q)
  `MNE_ASSERT_IMP(a_root_idle_at_start, state_q == mne_pkg::BK_LAST, !sqrt_busy)
  `MNE_ASSERT_IMP(a_result_from_finish, $rose(out_valid_q), $past(state_q == mne_pkg::BK_FINISH))
  `MNE_ASSERT_IMP(a_no_stage_in_tail, state_q == mne_pkg::BK_WALK || state_q == mne_pkg::BK_CLEAR, !s1_valid_q)

endmodule

@@ src/matrix_norm_engine_top.sv @@
// result: after the last word of a matrix the back walks the column sums and waits for
//   the square root, then loads the result word once the result side is free
// throughput: one word per cycle inside a matrix while full_o stays low, then a tail
//   per matrix, set by the serial square root and the column sum walk
// reset: config goes to one row and one column, then a clearing pass over every entry of
//   the column sum ram holds full high; a rows or columns register write repeats that pass
// ---------------------------------------------------------------------------
// matrix_norm_engine_top
// streaming max, infinity, one and frobenius norms over q16.16 matrix words
// ---------------------------------------------------------------------------
module matrix_norm_engine_top #(
  parameter int MaxCols = mne_pkg::MaxColsDef,
  localparam int ColW    = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  localparam int ColCntW = $clog2(MaxCols + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [mne_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mne_pkg::CfgDataW-1:0]     cfg_data_i,
  // input word queue side
  input  logic                             push_i,
  output logic                             full_o,
  input  logic signed [mne_pkg::ElemW-1:0] element_i,
  // result word queue side
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [mne_pkg::MagW-1:0]         max_abs_norm_o,
  output logic [mne_pkg::SumW-1:0]         infinity_norm_o,
  output logic [mne_pkg::SumW-1:0]         one_norm_o,
  output logic [mne_pkg::RootW-1:0]        frobenius_norm_o
);

  // config registers
  logic [mne_pkg::RowW-1:0]    row_cfg_q;
  logic [mne_pkg::ColCfgW-1:0] col_cfg_q;
  logic                        cfg_hit;

  // effective sizes, zero acts as one and columns clamp to MaxCols
  logic [mne_pkg::RowW-1:0]    rows_eff;
  logic [31:0]                 col_cfg_ext;
  logic [ColCntW-1:0]          cols_eff;

  // front to back queue
  logic                        q_empty, q_pop, clearing;
  logic [mne_pkg::MagW-1:0]    q_mag;
  logic [ColW-1:0]             q_col;
  mne_pkg::q_flags_t           q_flags;

  always_comb begin
    unique case (cfg_idx_i)
      mne_pkg::CFG_ROWS: cfg_hit = cfg_we_i;
      mne_pkg::CFG_COLS: cfg_hit = cfg_we_i;
      default:           cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= mne_pkg::RowW'(1);
      col_cfg_q <= mne_pkg::ColCfgW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mne_pkg::CFG_ROWS: row_cfg_q <= cfg_data_i;
        mne_pkg::CFG_COLS: col_cfg_q <= cfg_data_i[mne_pkg::ColCfgW-1:0];
        default: ;
      endcase
    end
  end

  assign rows_eff    = (row_cfg_q == '0) ? mne_pkg::RowW'(1) : row_cfg_q;
  assign col_cfg_ext = 32'(col_cfg_q);
  assign cols_eff    = (col_cfg_q == '0)               ? ColCntW'(1) :
                       (col_cfg_ext > 32'(MaxCols))    ? ColCntW'(MaxCols) :
                                                         ColCntW'(col_cfg_ext);

  // front: magnitude, row and column position, small queue
  mne_front #(
    .MaxCols (MaxCols)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cfg_hit),
    .hold_i    (clearing),
    .cols_i    (cols_eff),
    .rows_i    (rows_eff),
    .push_i    (push_i),
    .full_o    (full_o),
    .element_i (element_i),
    .q_pop_i   (q_pop),
    .q_empty_o (q_empty),
    .q_mag_o   (q_mag),
    .q_col_o   (q_col),
    .q_flags_o (q_flags)
  );

  // back: accumulators, column sum ram, per matrix tail and result register
  mne_back #(
    .MaxCols (MaxCols)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clr_i            (cfg_hit),
    .cols_i           (cols_eff),
    .clearing_o       (clearing),
    .q_empty_i        (q_empty),
    .q_mag_i          (q_mag),
    .q_col_i          (q_col),
    .q_flags_i        (q_flags),
    .q_pop_o          (q_pop),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .max_abs_norm_o   (max_abs_norm_o),
    .infinity_norm_o  (infinity_norm_o),
    .one_norm_o       (one_norm_o),
    .frobenius_norm_o (frobenius_norm_o)
  );

endmodule

@@ test/mne_norm_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// matrix norm checker
// follows config writes and pushed words, predicts the four norms of every
// finished matrix and compares them field by field with the popped words
// ---------------------------------------------------------------------------
module mne_norm_checker
  import mne_pkg::*;
#(
  parameter int MaxCols = MaxColsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push_i,
  input  logic                full_i,
  input  logic [ElemW-1:0]    element_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  logic [MagW-1:0]     max_abs_norm_i,
  input  logic [SumW-1:0]     infinity_norm_i,
  input  logic [SumW-1:0]     one_norm_i,
  input  logic [RootW-1:0]    frobenius_norm_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  words_in_o,
  output int                  results_out_o
);

  typedef struct {
    logic [MagW-1:0]  max_abs;
    logic [SumW-1:0]  inf_norm;
    logic [SumW-1:0]  one_norm;
    logic [RootW-1:0] frob;
  } norm_word_t;

  norm_word_t expected_norms_q[$];

  logic [RowW-1:0]    rows_reg;
  logic [ColCfgW-1:0] cols_reg;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [MagW-1:0]    peak_mag;
  logic [SumW-1:0]    row_acc;
  logic [SumW-1:0]    best_row;
  logic [SqW-1:0]     sq_acc;
  logic [SumW-1:0]    col_acc [MaxCols];

  function automatic int unsigned used_rows();
    return (rows_reg == '0) ? 1 : int'(rows_reg);
  endfunction

  function automatic int unsigned used_cols();
    if (cols_reg == '0) return 1;
    if (cols_reg > MaxCols) return MaxCols;
    return int'(cols_reg);
  endfunction

  function automatic logic [SumW-1:0] add_sum_sat(logic [SumW-1:0] a, logic [MagW-1:0] b);
    logic [SumW:0] s;
    s = a + b;
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  function automatic logic [SqW-1:0] add_sq_sat(logic [SqW-1:0] a, logic [MagW-1:0] m);
    logic [SqW:0] s;
    s = a + m * m;
    return s[SqW] ? '1 : s[SqW-1:0];
  endfunction

  // bit by bit search for the largest root whose square still fits
  function automatic logic [RootW-1:0] floor_root(logic [SqW-1:0] v);
    logic [RootW-1:0] r;
    logic [RootW-1:0] t;
    r = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      t = r | (RootW'(1) << b);
      if (SqW'(t) * SqW'(t) <= v) r = t;
    end
    return r;
  endfunction

  task automatic clear_matrix_state();
    col_pos  = 0;
    row_pos  = 0;
    peak_mag = '0;
    row_acc  = '0;
    best_row = '0;
    sq_acc   = '0;
    for (int k = 0; k < MaxCols; k++) col_acc[k] = '0;
  endtask

  task automatic take_element(input logic [ElemW-1:0] elem);
    logic [MagW-1:0] mag;
    logic            row_done;
    logic            last_word;
    logic [SumW-1:0] col_best;
    norm_word_t      nw;
    mag = elem[ElemW-1] ? ~elem + 1'b1 : elem;
    if (mag > peak_mag) peak_mag = mag;
    sq_acc           = add_sq_sat(sq_acc, mag);
    row_acc          = add_sum_sat(row_acc, mag);
    col_acc[col_pos] = add_sum_sat(col_acc[col_pos], mag);
    row_done  = (col_pos + 1 >= used_cols());
    last_word = row_done && (row_pos + 1 >= used_rows());
    if (row_done) begin
      if (row_acc > best_row) best_row = row_acc;
      row_acc = '0;
      col_pos = 0;
      row_pos = (row_pos + 1) & 16'hFFFF;
    end else begin
      col_pos++;
    end
    if (last_word) begin
      col_best = '0;
      for (int k = 0; k < used_cols(); k++)
        if (col_acc[k] > col_best) col_best = col_acc[k];
      nw.max_abs  = peak_mag;
      nw.inf_norm = best_row;
      nw.one_norm = col_best;
      nw.frob     = floor_root(sq_acc);
      expected_norms_q.push_back(nw);
      clear_matrix_state();
    end
  endtask

  task automatic check_result();
    norm_word_t nw;
    results_out_o++;
    if (expected_norms_q.size() == 0) begin
      if (fail_count_o < 10)
        $display("%0t: result word with nothing pending: max %h inf %h one %h frob %h",
                 $time, max_abs_norm_i, infinity_norm_i, one_norm_i, frobenius_norm_i);
      fail_count_o++;
    end else begin
      nw = expected_norms_q.pop_front();
      if (max_abs_norm_i !== nw.max_abs || infinity_norm_i !== nw.inf_norm ||
          one_norm_i !== nw.one_norm || frobenius_norm_i !== nw.frob) begin
        if (fail_count_o < 10) begin
          $display("%0t: norm mismatch, exp max %h inf %h one %h frob %h", $time,
                   nw.max_abs, nw.inf_norm, nw.one_norm, nw.frob);
          $display("%0t:                got max %h inf %h one %h frob %h", $time,
                   max_abs_norm_i, infinity_norm_i, one_norm_i, frobenius_norm_i);
        end
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg = 16'd1;
      cols_reg = 7'd1;
      clear_matrix_state();
      expected_norms_q.delete();
      fail_count_o  = 0;
      words_in_o    = 0;
      results_out_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS: begin
            rows_reg = cfg_data_i[RowW-1:0];
            clear_matrix_state();
          end
          CFG_COLS: begin
            cols_reg = cfg_data_i[ColCfgW-1:0];
            clear_matrix_state();
          end
          default: ;
        endcase
      end
      if (pop_i && !empty_i) check_result();
      if (push_i && !full_i) begin
        words_in_o++;
        take_element(element_i);
      end
    end
    pending_o = expected_norms_q.size();
  end

endmodule

@@ test/matrix_norm_engine_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// matrix norm engine testbench
// streams matrices of many shapes through the engine with random gaps on
// both queues, aborts some mid-way by config writes, and lets the checker
// compare every norm word
// ---------------------------------------------------------------------------
module matrix_norm_engine_top_tb;
  import mne_pkg::*;

  localparam int MaxCols      = MaxColsDef;
  localparam int ItemTarget   = 1350;
  // engine latency plus its per-matrix tail, with margin
  localparam int SettleCycles = 100;
  // no word moving for this long means the engine hung
  localparam int StallLimit   = 4000;

  // register indexes the engine does not decode
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  // element values at the edges of q16.16
  localparam logic [ElemW-1:0] ElemMostNeg = 32'h8000_0000;
  localparam logic [ElemW-1:0] ElemMostPos = 32'h7FFF_FFFF;
  localparam logic [ElemW-1:0] ElemMinusLsb = 32'hFFFF_FFFF;
  localparam logic [ElemW-1:0] ElemOne     = 32'h0001_0000;
  localparam logic [ElemW-1:0] ElemMinusOne = 32'hFFFF_0000;

  logic                clk_i      = 1'b1;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                push_i     = 1'b0;
  logic [ElemW-1:0]    element_i  = '0;
  logic                pop_i      = 1'b0;
  logic                full_o;
  logic                empty_o;
  logic [MagW-1:0]     max_abs_norm_o;
  logic [SumW-1:0]     infinity_norm_o;
  logic [SumW-1:0]     one_norm_o;
  logic [RootW-1:0]    frobenius_norm_o;

  int fail_count;
  int pending_words;
  int words_in;
  int results_out;

  // planning view of the config, the checker keeps its own
  logic [RowW-1:0]    rows_raw = 16'd1;
  logic [ColCfgW-1:0] cols_raw = 7'd1;

  int unsigned words_pushed = 0;
  int unsigned reg_writes   = 0;
  int unsigned shapes_run   = 0;
  int unsigned cut_short    = 0;
  int unsigned pop_wait     = 0;
  int unsigned stall_cycles = 0;
  bit          quiet_run    = 1'b0;

  matrix_norm_engine_top #(
    .MaxCols(MaxCols)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push_i),
    .full_o          (full_o),
    .element_i       (element_i),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .max_abs_norm_o  (max_abs_norm_o),
    .infinity_norm_o (infinity_norm_o),
    .one_norm_o      (one_norm_o),
    .frobenius_norm_o(frobenius_norm_o)
  );

  mne_norm_checker #(
    .MaxCols(MaxCols)
  ) norm_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push_i),
    .full_i          (full_o),
    .element_i       (element_i),
    .empty_i         (empty_o),
    .pop_i           (pop_i),
    .max_abs_norm_i  (max_abs_norm_o),
    .infinity_norm_i (infinity_norm_o),
    .one_norm_i      (one_norm_o),
    .frobenius_norm_i(frobenius_norm_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words),
    .words_in_o      (words_in),
    .results_out_o   (results_out)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b0;
    #2 clk_i = 1'b1;
  end

  // gap length: mostly none, sometimes a few cycles, rarely a long one
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // element mix: full random, small values, edge values and big magnitudes
  // that drive the sum of squares into saturation
  function automatic logic [ElemW-1:0] pick_element();
    int unsigned      r;
    logic [ElemW-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom;
    end else if (r < 65) begin
      v = $urandom_range(0, 1 << 18);
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 80) begin
      case ($urandom_range(0, 5))
        0:       v = ElemMostNeg;
        1:       v = ElemMostPos;
        2:       v = ElemMinusLsb;
        3:       v = ElemOne;
        4:       v = ElemMinusOne;
        default: v = '0;
      endcase
    end else begin
      v = $urandom | 32'h6000_0000;
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  // result side: pop goes high between random stalls
  always @(negedge clk_i) begin
    if (pop_wait != 0) begin
      pop_i <= 1'b0;
      pop_wait--;
    end else begin
      pop_i <= 1'b1;
      pop_wait = pick_gap(quiet_run);
    end
  end

  // watchdog: counts cycles in which no word and no register write moves
  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o) || cfg_we_i) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: watchdog, nothing moved for %0d cycles, %0d norm words pending",
                 $time, StallLimit, pending_words);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // push one word after a random gap, held until full drops at an edge
  task automatic drive_word(input logic [ElemW-1:0] value);
    int unsigned gap;
    gap = pick_gap(quiet_run);
    repeat (gap) begin
      @(negedge clk_i);
      push_i <= 1'b0;
    end
    @(negedge clk_i);
    push_i    <= 1'b1;
    element_i <= value;
    do @(posedge clk_i); while (full_o);
    words_pushed++;
  endtask

  // stop pushing, wait for every pending norm word, then let the tail finish
  task automatic settle_engine();
    @(negedge clk_i);
    push_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // write enable stays high across back to back writes, release_regs drops it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    reg_writes++;
    if (idx == CFG_ROWS) rows_raw = data[RowW-1:0];
    else if (idx == CFG_COLS) cols_raw = data[ColCfgW-1:0];
  endtask

  task automatic release_regs();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_shape(input logic [RowW-1:0] rows, input logic [CfgDataW-1:0] cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    release_regs();
  endtask

  task automatic directed_words();
    // reset shape is 1 x 1: every word is a whole matrix
    settle_engine();
    drive_word('0);
    drive_word(ElemMostPos);
    drive_word(ElemMostNeg);
    drive_word(ElemMinusLsb);
    drive_word(32'h0000_0001);

    // zero row and column counts behave as one
    settle_engine();
    set_shape(16'd0, 16'd0);
    drive_word(32'h0001_8000);
    drive_word(32'hFFFE_8000);

    // four most negative words overflow the sum of squares
    settle_engine();
    set_shape(16'd2, 16'd2);
    repeat (4) drive_word(ElemMostNeg);

    // upper column data bits are dropped; a spare index write mid-matrix
    // must leave the partial sums alone
    settle_engine();
    set_shape(16'd2, 16'hFF83);
    drive_word(ElemOne);
    drive_word(ElemMinusOne);
    settle_engine();
    write_reg(CfgIdxSpareHi, 16'hFFFF);
    release_regs();
    drive_word(32'h0003_0000);
    drive_word(ElemMostPos);
    drive_word(32'hFFF0_0000);
    drive_word(32'h0000_8000);

    // matrices cut short by the next config write, widest settings
    settle_engine();
    set_shape(16'd1, 16'd4);
    drive_word(ElemMostNeg);
    drive_word(ElemOne);
    settle_engine();
    set_shape(16'hFFFF, 16'd127);
    repeat (5) drive_word(pick_element());
    cut_short += 2;
  endtask

  task automatic random_shape();
    int unsigned        r;
    int unsigned        er;
    int unsigned        ec;
    int unsigned        m;
    int unsigned        k;
    int unsigned        total;
    int unsigned        split;
    bit                 spare;
    logic [RowW-1:0]    rows_pick;
    logic [ColCfgW-1:0] cols_pick;
    logic [CfgDataW-1:0] cols_data;

    settle_engine();
    quiet_run = ($urandom_range(0, 4) == 0);

    r = $urandom_range(0, 99);
    if (r < 70)      rows_pick = RowW'($urandom_range(1, 4));
    else if (r < 80) rows_pick = '0;
    else if (r < 90) rows_pick = RowW'($urandom_range(5, 12));
    else if (r < 95) rows_pick = '1;
    else             rows_pick = RowW'($urandom_range(13, 65535));

    r = $urandom_range(0, 99);
    if (r < 65)      cols_pick = ColCfgW'($urandom_range(1, 8));
    else if (r < 73) cols_pick = '0;
    else if (r < 83) cols_pick = ColCfgW'($urandom_range(9, MaxCols - 1));
    else if (r < 91) cols_pick = ColCfgW'(MaxCols);
    else             cols_pick = ColCfgW'($urandom_range(MaxCols + 1, 127));

    // junk in the unused upper column bits now and then
    cols_data = {9'(($urandom_range(0, 2) == 0) ? $urandom : 0), cols_pick};

    // at least one real register write per shape, in either order
    r = $urandom_range(0, 9);
    if (r < 4) begin
      write_reg(CFG_ROWS, rows_pick);
      write_reg(CFG_COLS, cols_data);
    end else if (r < 7) begin
      write_reg(CFG_COLS, cols_data);
      write_reg(CFG_ROWS, rows_pick);
    end else if (r == 7) begin
      write_reg(CFG_ROWS, rows_pick);
    end else begin
      write_reg(CFG_COLS, cols_data);
    end
    release_regs();

    er = (rows_raw == '0) ? 1 : rows_raw;
    ec = (cols_raw == '0) ? 1 : ((cols_raw > MaxCols) ? MaxCols : cols_raw);
    m  = er * ec;

    // small shapes: a few whole matrices, sometimes a broken one at the end
    // large shapes: only a slice, aborted by the next write
    if (m <= 130) begin
      k = $urandom_range(1, (130 / m > 4) ? 4 : 130 / m);
      total = k * m;
      if (m > 1 && $urandom_range(0, 3) == 0) begin
        total += $urandom_range(1, m - 1);
        cut_short++;
      end
    end else begin
      total = $urandom_range(1, 80);
      cut_short++;
    end

    spare = (total > 1) && ($urandom_range(0, 6) == 0);
    split = spare ? $urandom_range(1, total - 1) : 0;
    for (int i = 0; i < total; i++) begin
      if (spare && i == split) begin
        settle_engine();
        write_reg($urandom_range(0, 1) ? CfgIdxSpareHi : CfgIdxSpareLo, 16'($urandom));
        release_regs();
      end
      drive_word(pick_element());
    end
    shapes_run++;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_words();
    while (words_pushed < ItemTarget) random_shape();
    settle_engine();

    $display("run: %0d words pushed over %0d random shapes plus directed cases, %0d cut short",
             words_in, shapes_run, cut_short);
    $display("run: %0d register writes, %0d norm words checked, %0d failures",
             reg_writes, results_out, fail_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ matrix_norm_engine_top.f @@
+incdir+src
src/mne_pkg.sv
src/mne_ram.sv
src/mne_front.sv
src/mne_isqrt.sv
src/mne_back.sv
src/matrix_norm_engine_top.sv
test/mne_norm_checker.sv
test/matrix_norm_engine_top_tb.sv
